@@ rtl/fdx_pkg.sv @@
`default_nettype none

package fdx_pkg;

	// Frame format
	localparam logic [7:0]  HDR_BYTE      = 8'h23;
	localparam logic [7:0]  VERSION_RESET = 8'h14;
	localparam logic [15:0] MIN_FRAME     = 16'd10;
	localparam logic [15:0] MAX_FRAME     = 16'd64;

	// Byte buffer: candidate frame followed by bytes waiting for a rescan
	localparam int BUF_DEPTH = 64;
	localparam int PTR_W     = $clog2(BUF_DEPTH);
	localparam int CNT_W     = PTR_W + 1;

	typedef enum logic [2:0] {
		PH_HEAD1,
		PH_HEAD2,
		PH_LENHI,
		PH_LENLO,
		PH_VER,
		PH_BODY
	} phase_t;

	typedef enum logic [1:0] {
		FEED_MORE,
		FEED_DONE,
		FEED_FAIL
	} feed_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_FEED,
		ST_ERD,
		ST_ELD,
		ST_EOUT
	} state_t;

	typedef struct packed {
		logic feed_in;    // write and parse the byte of an input request
		logic feed_mem;   // parse the byte read back from the buffer
		logic rd_replay;  // read the next byte to rescan
		logic rd_emit;    // read the next frame byte to send
		logic out_load;   // capture read data into the output register
		logic emit_next;  // output byte taken
	} cmd_t;

	typedef struct packed {
		feed_res_t res;       // outcome of the byte parsed this cycle
		logic      feed_pend; // bytes remain to rescan after this parse
		logic      emit_pend; // bytes remain to rescan after the frame goes out
		logic      out_last;  // output register holds the checksum byte
	} stat_t;

endpackage

`default_nettype wire

@@ rtl/frame_deframer_xor_check.sv @@
`default_nettype none

// Byte-serial frame deframer. Received bytes enter on s_axis; a frame is
// 0x23 0x23, a 16-bit big-endian total length (10..64), a version byte equal
// to the value written on the cfg channel (reset 0x14), a body, and a final
// byte equal to the XOR of bytes 2 through length-2. Good frames leave on
// m_axis, one byte per transfer, with tlast on the checksum byte. On any
// header, length, version or checksum failure the buffered bytes after the
// failed start are parsed again. An input byte is written and parsed as it
// is taken; a rescanned byte is read back through the single read port of
// the 64-byte buffer and then parsed; a frame byte is read, loaded into the
// output register and held until m_axis takes it. s_axis_tready is low
// during rescans and frame output. No clearing pass is needed after
// reset. cfg_ready is always high; write cfg only while the block is idle.
module frame_deframer_xor_check
	import fdx_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] rx_byte
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic      [7:0] m_axis_tdata,   // [7:0] frame_byte
	output logic            m_axis_tlast,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_data        // [7:0] version_code
);

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	fdx_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.cmd          (cmd),
		.stat         (stat)
	);

	fdx_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_byte (s_axis_tdata),
		.cfg_we  (cfg_valid),
		.cfg_data(cfg_data),
		.cmd     (cmd),
		.stat    (stat),
		.out_byte(m_axis_tdata),
		.out_last(m_axis_tlast)
	);

endmodule

`default_nettype wire

@@ rtl/fdx_ram.sv @@
`default_nettype none

module fdx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/fdx_ctrl.sv @@
`default_nettype none

module fdx_ctrl
	import fdx_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  s_axis_tvalid,
	output logic       s_axis_tready,
	output logic       m_axis_tvalid,
	input  wire logic  m_axis_tready,
	output cmd_t       cmd,
	input  wire stat_t stat
);

	state_t st_q, st_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// Next state and commands
	always_comb begin
		st_d          = st_q;
		cmd           = '0;
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					cmd.feed_in = 1'b1;
					unique case (stat.res)
						FEED_DONE: st_d = ST_ERD;
						FEED_FAIL: st_d = stat.feed_pend ? ST_RD : ST_IDLE;
						default:   st_d = ST_IDLE;
					endcase
				end
			end
			ST_RD: begin
				cmd.rd_replay = 1'b1;
				st_d          = ST_FEED;
			end
			ST_FEED: begin
				cmd.feed_mem = 1'b1;
				unique case (stat.res)
					FEED_DONE: st_d = ST_ERD;
					default:   st_d = stat.feed_pend ? ST_RD : ST_IDLE;
				endcase
			end
			ST_ERD: begin
				cmd.rd_emit = 1'b1;
				st_d        = ST_ELD;
			end
			ST_ELD: begin
				cmd.out_load = 1'b1;
				st_d         = ST_EOUT;
			end
			ST_EOUT: begin
				m_axis_tvalid = 1'b1;
				if (m_axis_tready) begin
					cmd.emit_next = 1'b1;
					if (!stat.out_last) begin
						st_d = ST_ERD;
					end else begin
						st_d = stat.emit_pend ? ST_RD : ST_IDLE;
					end
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// A replay read is always followed by its parse
	a_rd_then_feed: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RD) |=> (st_q == ST_FEED))
		else $error("replay read not followed by parse");

	// Input is never taken while a frame byte is on offer
	a_no_in_during_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input taken during frame output");

endmodule

`default_nettype wire

@@ rtl/fdx_dp.sv @@
`default_nettype none

module fdx_dp
	import fdx_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] in_byte,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_data,
	input  wire cmd_t       cmd,
	output stat_t           stat,
	output logic      [7:0] out_byte,
	output logic            out_last
);

	logic [7:0]       version_q;
	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] total_q;
	logic [15:0]      len_q;
	logic [7:0]       xor_q;
	phase_t           phase_q;
	logic [PTR_W-1:0] emit_q;
	logic [7:0]       out_data_q;
	logic             out_last_q;

	logic [7:0]       rdata;
	logic [7:0]       b;
	logic             feed;
	logic [CNT_W-1:0] fill_inc;
	logic [CNT_W-1:0] total_eff;
	logic [PTR_W-1:0] waddr;
	logic [PTR_W-1:0] raddr;
	feed_res_t        res;
	phase_t           phase_d;
	logic [15:0]      len_d;
	logic [7:0]       xor_d;

	// Buffer addresses wrap around the head of the current candidate
	assign waddr     = head_q + total_q[PTR_W-1:0];
	assign raddr     = head_q + (cmd.rd_emit ? emit_q : fill_q[PTR_W-1:0]);
	assign feed      = cmd.feed_in | cmd.feed_mem;
	assign b         = cmd.feed_in ? in_byte : rdata;
	assign fill_inc  = fill_q + CNT_W'(1);
	assign total_eff = total_q + CNT_W'(cmd.feed_in);

	fdx_ram #(
		.WIDTH(8),
		.DEPTH(BUF_DEPTH)
	) u_buf (
		.clk  (clk),
		.we   (cmd.feed_in),
		.waddr(waddr),
		.wdata(in_byte),
		.re   (cmd.rd_replay | cmd.rd_emit),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Parse one byte against the frame header, length, version and checksum
	always_comb begin
		res     = FEED_MORE;
		phase_d = phase_q;
		len_d   = len_q;
		xor_d   = xor_q;
		unique case (phase_q)
			PH_HEAD1: begin
				if (b != HDR_BYTE) begin
					res = FEED_FAIL;
				end else begin
					phase_d = PH_HEAD2;
				end
			end
			PH_HEAD2: begin
				if (b != HDR_BYTE) begin
					res = FEED_FAIL;
				end else begin
					phase_d = PH_LENHI;
				end
			end
			PH_LENHI: begin
				len_d   = {b, 8'h00};
				xor_d   = xor_q ^ b;
				phase_d = PH_LENLO;
			end
			PH_LENLO: begin
				len_d = {len_q[15:8], b};
				xor_d = xor_q ^ b;
				if (len_d < MIN_FRAME || len_d > MAX_FRAME) begin
					res = FEED_FAIL;
				end else begin
					phase_d = PH_VER;
				end
			end
			PH_VER: begin
				xor_d = xor_q ^ b;
				if (b != version_q) begin
					res = FEED_FAIL;
				end else begin
					phase_d = PH_BODY;
				end
			end
			PH_BODY: begin
				if (16'(fill_inc) >= len_q) begin
					res = (b == xor_q) ? FEED_DONE : FEED_FAIL;
				end else begin
					xor_d = xor_q ^ b;
				end
			end
			default: res = FEED_FAIL;
		endcase
	end

	// Status back to the controller
	always_comb begin
		stat.res       = res;
		stat.feed_pend = (res == FEED_FAIL) ? (total_eff > CNT_W'(1)) : (fill_inc < total_eff);
		stat.emit_pend = (total_q != fill_q);
		stat.out_last  = out_last_q;
	end

	// Candidate state and buffer pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= VERSION_RESET;
			head_q    <= '0;
			fill_q    <= '0;
			total_q   <= '0;
			len_q     <= '0;
			xor_q     <= '0;
			phase_q   <= PH_HEAD1;
			emit_q    <= '0;
		end else begin
			if (cfg_we) begin
				version_q <= cfg_data;
			end
			if (feed) begin
				case (res)
					FEED_MORE: begin
						total_q <= total_eff;
						fill_q  <= fill_inc;
						phase_q <= phase_d;
						len_q   <= len_d;
						xor_q   <= xor_d;
					end
					FEED_DONE: begin
						total_q <= total_eff;
						fill_q  <= fill_inc;
						phase_q <= PH_HEAD1;
						len_q   <= '0;
						xor_q   <= '0;
						emit_q  <= '0;
					end
					default: begin
						// drop the failed start byte and rescan from the next one
						head_q  <= head_q + PTR_W'(1);
						total_q <= total_eff - CNT_W'(1);
						fill_q  <= '0;
						phase_q <= PH_HEAD1;
						len_q   <= '0;
						xor_q   <= '0;
					end
				endcase
			end
			if (cmd.emit_next) begin
				if (out_last_q) begin
					// release the sent frame from the buffer
					head_q  <= head_q + fill_q[PTR_W-1:0];
					total_q <= total_q - fill_q;
					fill_q  <= '0;
				end else begin
					emit_q <= emit_q + PTR_W'(1);
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= rdata;
			out_last_q <= ((CNT_W'(emit_q) + CNT_W'(1)) == fill_q);
		end
	end

	assign out_byte = out_data_q;
	assign out_last = out_last_q;

	a_fill_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= total_q)
		else $error("candidate longer than buffered bytes");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_W'(BUF_DEPTH))
		else $error("buffer overfilled");

	a_frame_released: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_next && out_last_q) |=> (fill_q == '0))
		else $error("frame not released after last byte");

endmodule

`default_nettype wire
